### src/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants, types and arithmetic helpers for the RGB to I420
// pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

   // largest frame dimension the counters support
   localparam int MAX_DIM = 4096;

   localparam int PIX_W         = 8;
   localparam int DIM_W         = 13;
   localparam int DIM_CMP_W     = 14;
   localparam int CNT_W         = $clog2(MAX_DIM);
   localparam int LUMA_ADDR_W   = 24;
   localparam int CHROMA_ADDR_W = 22;

   // weighted sums stay below 2^18 (max 256000)
   localparam int SUM_W = 18;

   // floor(x / 1000) = (x * 67109) >> 26, exact for x < 2^18
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 26;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam int QUOT_W      = 9;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 17'd67109;

   localparam logic [SUM_W-1:0] Y_KR        = 18'd299;
   localparam logic [SUM_W-1:0] Y_KG        = 18'd587;
   localparam logic [SUM_W-1:0] Y_KB        = 18'd114;
   localparam logic [SUM_W-1:0] CB_KR       = 18'd169;
   localparam logic [SUM_W-1:0] CB_KG       = 18'd331;
   localparam logic [SUM_W-1:0] CB_KB       = 18'd500;
   localparam logic [SUM_W-1:0] CR_KR       = 18'd500;
   localparam logic [SUM_W-1:0] CR_KG       = 18'd419;
   localparam logic [SUM_W-1:0] CR_KB       = 18'd81;
   localparam logic [SUM_W-1:0] ROUND_BIAS  = 18'd500;
   localparam logic [SUM_W-1:0] CHROMA_BIAS = 18'd128500;

   localparam logic [QUOT_W-1:0] LUMA_MIN   = 9'd16;
   localparam logic [QUOT_W-1:0] LUMA_MAX   = 9'd235;
   localparam logic [QUOT_W-1:0] CHROMA_MIN = 9'd16;
   localparam logic [QUOT_W-1:0] CHROMA_MAX = 9'd240;

   localparam logic [DIM_W-1:0]     FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0]     FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [DIM_CMP_W-1:0] DIM_LOW            = 14'd2;
   localparam logic [DIM_CMP_W-1:0] DIM_HIGH           = DIM_CMP_W'(MAX_DIM);

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // first pipeline stage: weighted sums plus the per-pixel control fields
   typedef struct packed {
      logic [SUM_W-1:0]         luma_sum;
      logic [SUM_W-1:0]         cb_sum;
      logic [SUM_W-1:0]         cr_sum;
      logic                     chroma_valid;
      logic [LUMA_ADDR_W-1:0]   luma_addr;
      logic [CHROMA_ADDR_W-1:0] chroma_addr;
      logic                     frame_end;
   } sums_type;

   // last index of a dimension after limiting it to DIM_LOW..DIM_HIGH
   function automatic logic [CNT_W-1:0] last_index(input logic [DIM_W-1:0] dim);
      logic [DIM_CMP_W-1:0] d;
      logic [DIM_CMP_W-1:0] e;
      d = DIM_CMP_W'(dim);
      if (d < DIM_LOW) begin
         e = DIM_LOW;
      end else if (d > DIM_HIGH) begin
         e = DIM_HIGH;
      end else begin
         e = d;
      end
      last_index = CNT_W'(e - DIM_CMP_W'(1));
   endfunction

   function automatic logic [QUOT_W-1:0] div1000(input logic [SUM_W-1:0] sum);
      logic [PROD_W-1:0] prod;
      prod    = PROD_W'(sum) * PROD_W'(RECIP_MULT);
      div1000 = prod[RECIP_SHIFT +: QUOT_W];
   endfunction

   function automatic logic [PIX_W-1:0] clamp_pix(input logic [QUOT_W-1:0] q,
                                                  input logic [QUOT_W-1:0] lo,
                                                  input logic [QUOT_W-1:0] hi);
      logic [QUOT_W-1:0] c;
      if (q < lo) begin
         c = lo;
      end else if (q > hi) begin
         c = hi;
      end else begin
         c = q;
      end
      clamp_pix = c[PIX_W-1:0];
   endfunction

endpackage

`default_nettype wire

### src/rgb_to_i420_converter.sv
// A pixel is registered in stage 1 and then in stage 2, whose registers drive rsp_*.
// Throughput: one pixel per cycle while rsp_ready is high; the two registered stages
// (weighted sums, then the reciprocal multiply and clamp) each hold one pixel.
// Reset: synchronous, active high; clears the valids, the column and row counters and the
// plane indices, and sets frame_width to 640 and frame_height to 480.
// ----------------------------------------------------------------------------
// rgb_to_i420_converter
// Converts a raster RGB pixel stream to BT.601 luma and top-left decimated
// chroma samples with plane addresses and an end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_i420_converter (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration
   input  wire logic                                  csr_wr_en,
   input  wire logic [0:0]                            csr_index,
   input  wire logic [rti_pkg::DIM_W-1:0]             csr_wdata,
   // pixel input
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   input  wire logic [rti_pkg::PIX_W-1:0]             req_red,
   input  wire logic [rti_pkg::PIX_W-1:0]             req_green,
   input  wire logic [rti_pkg::PIX_W-1:0]             req_blue,
   // sample output
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      logic [rti_pkg::PIX_W-1:0]             rsp_luma,
   output      logic [rti_pkg::PIX_W-1:0]             rsp_chroma_blue,
   output      logic [rti_pkg::PIX_W-1:0]             rsp_chroma_red,
   output      logic                                  rsp_chroma_valid,
   output      logic [rti_pkg::LUMA_ADDR_W-1:0]       rsp_luma_addr,
   output      logic [rti_pkg::CHROMA_ADDR_W-1:0]     rsp_chroma_addr,
   output      logic                                  rsp_frame_end
);

   logic [rti_pkg::DIM_W-1:0]         frame_width_ff;
   logic [rti_pkg::DIM_W-1:0]         frame_height_ff;
   logic [rti_pkg::CNT_W-1:0]         col_ff,  col_in;
   logic [rti_pkg::CNT_W-1:0]         row_ff,  row_in;
   logic [rti_pkg::LUMA_ADDR_W-1:0]   luma_idx_ff,   luma_idx_in;
   logic [rti_pkg::CHROMA_ADDR_W-1:0] chroma_idx_ff, chroma_idx_in;

   logic                  s1_valid_ff;
   rti_pkg::sums_type     s1_ff, s1_in;

   logic                                 out_valid_ff;
   logic [rti_pkg::PIX_W-1:0]            luma_ff, luma_in;
   logic [rti_pkg::PIX_W-1:0]            cb_ff,   cb_in;
   logic [rti_pkg::PIX_W-1:0]            cr_ff,   cr_in;
   logic                                 cvalid_ff;
   logic [rti_pkg::LUMA_ADDR_W-1:0]      luma_addr_ff;
   logic [rti_pkg::CHROMA_ADDR_W-1:0]    chroma_addr_ff;
   logic                                 frame_end_ff;

   logic                      s2_load;
   logic                      accept;
   logic [rti_pkg::CNT_W-1:0] last_col_idx;
   logic [rti_pkg::CNT_W-1:0] last_row_idx;
   logic                      last_col;
   logic                      last_row;
   logic                      cvalid;
   logic                      fend;
   logic [rti_pkg::SUM_W-1:0] r_ext, g_ext, b_ext;

   // handshake: each stage loads when it is empty or its contents move on
   assign s2_load   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s2_load;
   assign accept    = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= rti_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= rti_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (rti_pkg::csr_index_type'(csr_index))
            rti_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            rti_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // raster position and plane indices
   always_comb begin
      last_col_idx = rti_pkg::last_index(frame_width_ff);
      last_row_idx = rti_pkg::last_index(frame_height_ff);
      last_col     = col_ff >= last_col_idx;
      last_row     = row_ff >= last_row_idx;
      fend         = last_col && last_row;
      cvalid       = !col_ff[0] && !row_ff[0];

      if (fend) begin
         col_in        = '0;
         row_in        = '0;
         luma_idx_in   = '0;
         chroma_idx_in = '0;
      end else begin
         luma_idx_in   = luma_idx_ff + rti_pkg::LUMA_ADDR_W'(1);
         chroma_idx_in = cvalid ? chroma_idx_ff + rti_pkg::CHROMA_ADDR_W'(1)
                                : chroma_idx_ff;
         if (last_col) begin
            col_in = '0;
            row_in = row_ff + rti_pkg::CNT_W'(1);
         end else begin
            col_in = col_ff + rti_pkg::CNT_W'(1);
            row_in = row_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         luma_idx_ff   <= '0;
         chroma_idx_ff <= '0;
      end else if (accept) begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         luma_idx_ff   <= luma_idx_in;
         chroma_idx_ff <= chroma_idx_in;
      end
   end

   // stage 1: weighted sums with rounding and chroma offset folded in;
   // all sums are nonnegative, so modulo 2^SUM_W arithmetic is exact
   always_comb begin
      r_ext = rti_pkg::SUM_W'(req_red);
      g_ext = rti_pkg::SUM_W'(req_green);
      b_ext = rti_pkg::SUM_W'(req_blue);

      s1_in.luma_sum = rti_pkg::Y_KR * r_ext + rti_pkg::Y_KG * g_ext
                     + rti_pkg::Y_KB * b_ext + rti_pkg::ROUND_BIAS;
      s1_in.cb_sum   = rti_pkg::CB_KB * b_ext + rti_pkg::CHROMA_BIAS
                     - rti_pkg::CB_KR * r_ext - rti_pkg::CB_KG * g_ext;
      s1_in.cr_sum   = rti_pkg::CR_KR * r_ext + rti_pkg::CHROMA_BIAS
                     - rti_pkg::CR_KG * g_ext - rti_pkg::CR_KB * b_ext;
      s1_in.chroma_valid = cvalid;
      s1_in.luma_addr    = luma_idx_ff;
      s1_in.chroma_addr  = cvalid ? chroma_idx_ff : '0;
      s1_in.frame_end    = fend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: divide by 1000 through the reciprocal, then clamp
   always_comb begin
      luma_in = rti_pkg::clamp_pix(rti_pkg::div1000(s1_ff.luma_sum),
                                   rti_pkg::LUMA_MIN, rti_pkg::LUMA_MAX);
      cb_in   = '0;
      cr_in   = '0;
      if (s1_ff.chroma_valid) begin
         cb_in = rti_pkg::clamp_pix(rti_pkg::div1000(s1_ff.cb_sum),
                                    rti_pkg::CHROMA_MIN, rti_pkg::CHROMA_MAX);
         cr_in = rti_pkg::clamp_pix(rti_pkg::div1000(s1_ff.cr_sum),
                                    rti_pkg::CHROMA_MIN, rti_pkg::CHROMA_MAX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         luma_ff        <= luma_in;
         cb_ff          <= cb_in;
         cr_ff          <= cr_in;
         cvalid_ff      <= s1_ff.chroma_valid;
         luma_addr_ff   <= s1_ff.luma_addr;
         chroma_addr_ff <= s1_ff.chroma_addr;
         frame_end_ff   <= s1_ff.frame_end;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_luma         = luma_ff;
   assign rsp_chroma_blue  = cb_ff;
   assign rsp_chroma_red   = cr_ff;
   assign rsp_chroma_valid = cvalid_ff;
   assign rsp_luma_addr    = luma_addr_ff;
   assign rsp_chroma_addr  = chroma_addr_ff;
   assign rsp_frame_end    = frame_end_ff;

endmodule

`default_nettype wire
